>>> rtl/gcd_lcm_unit_core_defines.svh
// Assertion macros shared by the gcd/lcm unit RTL.
// Expects clk and rst_n in the scope where they are used.
`ifndef GCD_LCM_UNIT_CORE_DEFINES_SVH
`define GCD_LCM_UNIT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/glu_pkg.sv
// Shared types for the gcd/lcm unit: controller states and the
// command/status bundles between controller and datapath.
package glu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic gcd_run;
        logic gcd_latch;
        logic div_start;
        logic div_run;
        logic mul_start;
        logic mul_run;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic cnt_zero;
        logic is_lcm;
        logic has_zero;
    } status_t;

    localparam logic OP_GCD = 1'b0;
    localparam logic OP_LCM = 1'b1;

endpackage

>>> rtl/glu_datapath.sv
// Datapath of the gcd/lcm unit: binary gcd, restoring divider,
// shift-add multiplier and result register. Depends on glu_pkg.
module glu_datapath
    import glu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  opcode,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic                  overflow
);

    localparam int KW = $clog2(DATA_WIDTH);
    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(DATA_WIDTH);

    logic                  op_reg;
    logic                  zero_reg;
    logic [DATA_WIDTH-1:0] a_reg, b_reg;
    logic [DATA_WIDTH-1:0] x_reg, y_reg;
    logic [KW-1:0]         k_reg;
    logic [DATA_WIDTH-1:0] g_reg;
    logic [DATA_WIDTH-1:0] rem_reg, quo_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic                  ovf_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic                  res_ovf_reg;

    logic [DATA_WIDTH-1:0] gcd_val;
    logic [DATA_WIDTH:0]   rem_shift, rem_diff;
    logic                  rem_ge;
    logic [DATA_WIDTH+1:0] mul_addend, mul_sum;

    // Once one side hits zero the other side holds the gcd without the common factors of two counted in k_reg.
    assign gcd_val = (x_reg | y_reg) << k_reg;

    assign rem_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, g_reg};
    assign rem_diff  = rem_shift - {1'b0, g_reg};

    // Quotient bits are consumed MSB first; the running value never shrinks,
    // so a sticky flag on the top bits is the exact overflow.
    assign mul_addend = quo_reg[DATA_WIDTH-1] ? {2'b00, b_reg} : '0;
    assign mul_sum    = {1'b0, acc_reg, 1'b0} + mul_addend;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            zero_reg <= (operand_a == '0) || (operand_b == '0);
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            x_reg    <= operand_a;
            y_reg    <= operand_b;
            k_reg    <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.gcd_run)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!x_reg[0])
            begin
                x_reg <= x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_reg <= y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_reg <= x_reg - y_reg;
            end
            else
            begin
                y_reg <= y_reg - x_reg;
            end
        end

        if (cmd.gcd_latch)
        begin
            g_reg <= gcd_val;
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= a_reg;
            cnt_reg <= CNT_INIT;
        end
        else if (cmd.div_run)
        begin
            rem_reg <= rem_ge ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], rem_ge};
            cnt_reg <= cnt_reg - CW'(1);
        end
        else if (cmd.mul_start)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= CNT_INIT;
        end
        else if (cmd.mul_run)
        begin
            acc_reg <= mul_sum[DATA_WIDTH-1:0];
            ovf_reg <= ovf_reg || (mul_sum[DATA_WIDTH+1:DATA_WIDTH] != 2'b00);
            quo_reg <= quo_reg << 1;
            cnt_reg <= cnt_reg - CW'(1);
        end

        if (cmd.out_load)
        begin
            res_reg     <= (op_reg == OP_LCM) ? acc_reg : g_reg;
            res_ovf_reg <= (op_reg == OP_LCM) && ovf_reg;
        end
    end

    always_comb
    begin
        status.gcd_done = (x_reg == '0) || (y_reg == '0);
        status.cnt_zero = (cnt_reg == '0);
        status.is_lcm   = (op_reg == OP_LCM);
        status.has_zero = zero_reg;
    end

    assign result_value = res_reg;
    assign overflow     = res_ovf_reg;

endmodule

>>> rtl/glu_ctrl.sv
// Controller of the gcd/lcm unit: sequences gcd, divide and multiply
// phases and owns the handshake flags. Depends on glu_pkg.
module glu_ctrl
    import glu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = (status.is_lcm && !status.has_zero) ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (status.cnt_zero)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.cnt_zero)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_GCD:
            begin
                cmd.gcd_run   = !status.gcd_done;
                cmd.gcd_latch = status.gcd_done;
                cmd.div_start = status.gcd_done && status.is_lcm && !status.has_zero;
            end
            ST_DIV:
            begin
                cmd.div_run   = !status.cnt_zero;
                cmd.mul_start = status.cnt_zero;
            end
            ST_MUL:
            begin
                cmd.mul_run = !status.cnt_zero;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/gcd_lcm_unit_core.sv
// gcd/lcm unit top level: glu_ctrl plus glu_datapath; uses glu_pkg and the defines header.
// Sequence: gcd runs the binary-gcd loop; lcm with both operands nonzero then adds the
// bit-serial divider (a / gcd) and the shift-add multiplier (quotient * b).
// Throughput: one item at a time, set by the one-step-per-cycle gcd and shift loops.
// The next item is taken while a finished result waits in the output register.
// Reset (async, active low) clears the controller and output valid; no data state.
`include "gcd_lcm_unit_core_defines.svh"

module gcd_lcm_unit_core
    import glu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] result_value,
    output logic                  overflow
);

    cmd_t       cmd;
    status_t    status;
    logic [3:0] dp_ops;

    glu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    glu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .result_value (result_value),
        .overflow     (overflow)
    );

    assign dp_ops = {cmd.load, cmd.gcd_run, cmd.div_run, cmd.mul_run};

    // One datapath operation per cycle at most.
    `GLU_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0(dp_ops), "datapath commands overlap")

    // An accepted beat makes the unit busy.
    `GLU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // A loaded result is presented on the next cycle.
    `GLU_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid, "loaded result not presented")

    // Output register is only written when free or being drained.
    `GLU_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")

endmodule

>>> sim/tb_gcd_lcm_unit_core.sv
// Testbench for gcd_lcm_unit_core: directed and random gcd/lcm beats, checked in order.
// A scoreboard class predicts each result; it depends on glu_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb_gcd_lcm_unit_core;
    import glu_pkg::*;

    localparam int DATA_WIDTH  = 32;
    localparam int N_ITEMS     = 1050;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = 300;

    typedef logic [DATA_WIDTH-1:0] word_t;

    class gcd_lcm_scoreboard;
        typedef struct {
            word_t value;
            logic  ovf;
        } glu_result_t;

        glu_result_t expected_results[$];
        int          n_accepted;
        int          n_errors;

        function new();
            n_accepted = 0;
            n_errors   = 0;
        endfunction

        static function word_t euclid_gcd(word_t x, word_t y);
            word_t r;
            while (y != '0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        static function glu_result_t predict_result(logic op, word_t a, word_t b);
            glu_result_t           res;
            word_t                 g;
            word_t                 q;
            logic [2*DATA_WIDTH-1:0] prod;
            res.value = '0;
            res.ovf   = 1'b0;
            if (op == OP_GCD)
            begin
                res.value = euclid_gcd(a, b);
            end
            else if (a != '0 && b != '0)
            begin
                g         = euclid_gcd(a, b);
                q         = a / g;
                prod      = {{DATA_WIDTH{1'b0}}, q} * {{DATA_WIDTH{1'b0}}, b};
                res.value = prod[DATA_WIDTH-1:0];
                res.ovf   = |prod[2*DATA_WIDTH-1:DATA_WIDTH];
            end
            return res;
        endfunction

        function void note_input(logic op, word_t a, word_t b);
            expected_results.push_back(predict_result(op, a, b));
            n_accepted++;
        endfunction

        function void check_result(word_t value, logic ovf);
            glu_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: result_value %h overflow %b", value, ovf);
                n_errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (value !== exp_res.value)
            begin
                $error("result_value mismatch: expected %h, actual %h", exp_res.value, value);
                n_errors++;
            end
            if (ovf !== exp_res.ovf)
            begin
                $error("overflow mismatch: expected %b, actual %b", exp_res.ovf, ovf);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    logic  opcode    = 1'b0;
    word_t operand_a = '0;
    word_t operand_b = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t result_value;
    logic  overflow;

    gcd_lcm_scoreboard sb;
    int unsigned       cycle_count = 0;
    bit                no_idle     = 1'b0;

    gcd_lcm_unit_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .overflow     (overflow)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        else if ($urandom_range(0, 2) == 0)
            return 0;
        else
            return $urandom_range(1, 3);
    endfunction

    function automatic word_t pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(1, 100);
            2:       return $urandom_range(0, 16'hFFFF);
            3:       return word_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
            4:       return '1 - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic op, input word_t a, input word_t b);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op, a, b);
    endtask

    // result side: random stalls, quiet windows, and one long hold-off
    initial
    begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(result_value, overflow);
            if (!held && sb.n_accepted >= 300)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ((cycle_count / 5000) % 3 != 0 && $urandom_range(0, 1) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        logic  op;
        word_t a;
        word_t b;
        word_t f;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero operands, extremes, worst-case Euclid chain, lcm fit/overflow edges
        send_item(OP_GCD, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_GCD, 32'd12345,     32'h0000_0000);
        send_item(OP_GCD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_GCD, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(OP_GCD, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(OP_GCD, 32'h8000_0000, 32'h4000_0000);
        send_item(OP_GCD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(OP_GCD, 32'd48,        32'd18);
        send_item(OP_GCD, 32'd2971215073, 32'd1836311903);
        send_item(OP_LCM, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_LCM, 32'h0000_0000, 32'd7);
        send_item(OP_LCM, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_LCM, 32'h0000_0001, 32'h0000_0001);
        send_item(OP_LCM, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(OP_LCM, 32'h0001_0001, 32'h0000_FFFF);
        send_item(OP_LCM, 32'h0001_0001, 32'h0001_0000);
        send_item(OP_LCM, 32'h8000_0000, 32'd2);
        send_item(OP_LCM, 32'h8000_0000, 32'd3);
        send_item(OP_LCM, 32'd4,         32'd6);
        send_item(OP_LCM, 32'd2971215073, 32'd1836311903);

        for (int i = 0; i < N_ITEMS - 23; i++)
        begin
            no_idle = ((i / 64) % 4 == 3);
            op = $urandom_range(0, 1) ? OP_LCM : OP_GCD;
            if ($urandom_range(0, 3) == 0)
            begin
                // shared factor so the gcd is not trivially 1
                f = $urandom_range(1, 16'hFFFF);
                a = f * $urandom_range(0, 16'hFFFF);
                b = f * $urandom_range(0, 16'hFFFF);
            end
            else
            begin
                a = pick_operand();
                b = pick_operand();
            end
            send_item(op, a, b);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
